/* src/bect_pkg.sv */
// Package with shared types, character codes and result codes of the token checker.
`timescale 1ns / 1ps
package bect_pkg;

  // Deepest bracket nesting that is accepted.
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // Result queue depth and the widths that follow from it.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_OPERATOR = 3'd2;
  localparam logic [2:0] ERR_BRACKET  = 3'd3;
  localparam logic [2:0] ERR_FLOATING = 3'd4;
  localparam logic [2:0] ERR_DEEP     = 3'd5;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_XOR   = 8'h5E;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_NOT   = 8'h21;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] code;
    logic       last;
  } result_t;

  // Results produced by one request and how many of them are valid.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } result_pair_t;

  function automatic logic is_operand(input logic [7:0] c);
    is_operand = (c == CH_ZERO) || (c == CH_ONE) ||
                 (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

endpackage

/* src/bect_core.sv */
// Checker state and the per-request classification that yields up to two results.
`timescale 1ns / 1ps
module bect_core import bect_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_acc,
  input  logic         req_type,
  input  logic [7:0]   req_char,
  output result_pair_t res
);

  logic               expect_r, expect_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [2:0]         err_r, err_nxt;

  always_comb begin
    logic [2:0] err;
    err        = ERR_NONE;
    expect_nxt = expect_r;
    depth_nxt  = depth_r;
    err_nxt    = err_r;
    res        = '0;

    if (req_type == REQ_END) begin
      if (err_r != ERR_NONE) begin
        err = err_r;
      end else if (!expect_r) begin
        err = ERR_FLOATING;
      end else if (depth_r != '0) begin
        err = ERR_BRACKET;
      end
      res.num         = 2'd1;
      res.first.kind  = (err != ERR_NONE) ? KIND_ERROR : KIND_ACCEPT;
      res.first.code  = err;
      res.first.last  = 1'b1;
      expect_nxt      = 1'b0;
      depth_nxt       = '0;
      err_nxt         = ERR_NONE;
    end else if (err_r == ERR_NONE && req_char != CH_SPACE) begin
      if (is_operand(req_char) || req_char == CH_OPEN || req_char == CH_NOT) begin
        if (req_char == CH_OPEN && depth_r >= DEPTH_W'(MAX_DEPTH)) begin
          err = ERR_DEEP;
        end else begin
          expect_nxt = is_operand(req_char);
          if (req_char == CH_OPEN) begin
            depth_nxt = depth_r + 1'b1;
          end
          // An implicit AND goes out ahead of the operand, '(' or '!'.
          if (expect_r) begin
            res.num         = 2'd2;
            res.first.kind  = KIND_CHAR;
            res.first.ch    = CH_STAR;
            res.second.kind = KIND_CHAR;
            res.second.ch   = req_char;
            res.second.last = 1'b1;
          end else begin
            res.num         = 2'd1;
            res.first.kind  = KIND_CHAR;
            res.first.ch    = req_char;
            res.first.last  = 1'b1;
          end
        end
      end else if (expect_r) begin
        if (req_char == CH_CLOSE) begin
          if (depth_r == '0) begin
            err = ERR_BRACKET;
          end else begin
            depth_nxt = depth_r - 1'b1;
          end
        end else if (req_char == CH_STAR || req_char == CH_PLUS || req_char == CH_XOR) begin
          expect_nxt = 1'b0;
        end else if (req_char != CH_QUOTE) begin
          err = ERR_UNKNOWN;
        end
        if (err == ERR_NONE) begin
          res.num        = 2'd1;
          res.first.kind = KIND_CHAR;
          res.first.ch   = req_char;
          res.first.last = 1'b1;
        end
      end else begin
        err = ERR_OPERATOR;
      end

      // A failing character leaves the rest of the state alone.
      if (err != ERR_NONE) begin
        expect_nxt     = expect_r;
        depth_nxt      = depth_r;
        err_nxt        = err;
        res.num        = 2'd1;
        res.first      = '0;
        res.first.kind = KIND_ERROR;
        res.first.code = err;
        res.first.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b0;
      depth_r  <= '0;
      err_r    <= ERR_NONE;
    end else if (req_acc) begin
      expect_r <= expect_nxt;
      depth_r  <= depth_nxt;
      err_r    <= err_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc && req_type == REQ_END |=> !expect_r && depth_r == '0 && err_r == ERR_NONE)
    else $error("state not cleared after end request");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("bracket depth beyond bound");

  a_err_held: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_NONE && !(req_acc && req_type == REQ_END) |=> err_r == $past(err_r))
    else $error("latched error changed before end request");

endmodule

/* src/bect_res_fifo.sv */
// Small result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps
module bect_res_fifo import bect_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  result_pair_t push,
  output logic         full2,
  output logic         pop_valid,
  input  logic         pop,
  output result_t      head
);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_1;

  // Room for two results is needed before a request is taken.
  assign full2     = count_r > CNT_W'(FIFO_DEPTH - 2);
  assign pop_valid = count_r != '0;
  assign head      = mem[rd_ptr_r];
  assign wr_ptr_1  = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> (count_r - CNT_W'(pop)) <= CNT_W'(FIFO_DEPTH) - CNT_W'(push.num))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("result queue underflow");

endmodule

/* src/bool_expr_token_checker_unit.sv */
// Top level of the Boolean expression token checker.
// Takes one expression character per request and streams out the normalized
// characters, with spaces dropped and '*' inserted for implicit AND; an end
// request gives the verdict (accepted or an error code) and clears the state.
// The first error is latched and reported, then again as the end verdict; later
// characters of that expression give no result until the end request. A request
// is taken in the cycle it arrives unless stalled; its results are registered in
// the result queue. Requests that give one result are taken every cycle while
// the output is not stalled; a request that inserts '*' gives two results, and
// as the port hands out one per cycle, dense runs stall. A four-entry result
// queue sets this: a request is stalled while fewer than two entries are free.
`timescale 1ns / 1ps
module bool_expr_token_checker_unit import bect_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_char,
  output logic [2:0] out_err_code,
  output logic       out_last
);

  logic         in_acc;
  logic         full2;
  result_pair_t res;
  result_pair_t push;
  result_t      head;

  assign in_stall = full2;
  assign in_acc   = in_valid && !full2;

  bect_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_acc  (in_acc),
    .req_type (in_req_type),
    .req_char (in_char),
    .res      (res)
  );

  always_comb begin
    push = res;
    if (!in_acc) begin
      push.num = 2'd0;
    end
  end

  bect_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full2     (full2),
    .pop_valid (out_valid),
    .pop       (out_valid && !out_stall),
    .head      (head)
  );

  assign out_kind     = head.kind;
  assign out_char     = head.ch;
  assign out_err_code = head.code;
  assign out_last     = head.last;

endmodule
